@@ sv/sld_pkg.sv @@
`default_nettype none

package sld_pkg;

    // Fixed-point format and sine-squared table size
    localparam int FRAC_BITS  = 16;
    localparam int SIN2_DEPTH = 256;

    localparam int DATA_W      = 32;
    localparam int CFG_INDEX_W = 3;

    // Pipeline depth: one register stage per entry
    localparam int NUM_STAGES = 10;

    // Derived widths
    localparam int IDX_W      = $clog2(SIN2_DEPTH + 1);
    localparam int SCALE_W    = FRAC_BITS + 1;
    localparam int PH_W       = FRAC_BITS + 1;
    localparam int ETA_PROD_W = 2 * FRAC_BITS + 1;
    localparam int IDXP_W     = PH_W + IDX_W + 1;
    localparam int ST_PROD_W  = SCALE_W + 31;

    localparam logic [63:0] ROUND_HALF = 64'd1 << (FRAC_BITS - 1);
    localparam logic [30:0] ONE_Q31    = 31'(64'd1 << FRAC_BITS);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BOUNDARY_POSITION = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MEASURE_FROM_UPPER = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LAYER_WIDTH       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_WIDTH     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERSE_TAU       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP         = 3'd5;

    // Per-stage advance strobes shared by the datapath lanes
    typedef logic [NUM_STAGES-1:0] sld_adv_t;

    typedef logic [SCALE_W-1:0] sin2_table_t [0:SIN2_DEPTH];

    // Restoring long division, evaluated only while the table is built
    function automatic longint unsigned const_udiv(
        input longint unsigned numer,
        input longint unsigned denom
    );
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = (rem << 1) | ((numer >> b) & 64'd1);
            if (rem >= denom)
            begin
                rem = rem - denom;
                quo = quo | (64'd1 << b);
            end
        end
        return quo;
    endfunction

    // sin^2(pi/2 * k / DEPTH) in Q.F via integer Taylor series of sin
    function automatic sin2_table_t build_sin2_table();
        sin2_table_t       tbl;
        longint unsigned   t;
        longint unsigned   t2;
        longint unsigned   term;
        longint unsigned   n;
        longint unsigned   sq;
        longint unsigned   e;
        longint            s;
        for (int k = 0; k <= SIN2_DEPTH; k++)
        begin
            t    = (HALF_PI_Q30 * 64'(k) + 64'(SIN2_DEPTH / 2)) / 64'(SIN2_DEPTH);
            t2   = (t * t) >> 30;
            term = t;
            s    = longint'(t);
            n    = 1;
            while (n < 20 && term != 0)
            begin
                term = const_udiv((term * t2) >> 30, (2 * n) * (2 * n + 1));
                if (n[0])
                    s = s - longint'(term);
                else
                    s = s + longint'(term);
                n = n + 1;
            end
            if (s < 0)
                s = 0;
            if (s > (64'sd1 <<< 30))
                s = 64'sd1 <<< 30;
            sq = longint'(s) * longint'(s);
            e  = (sq + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
            if (e > (64'd1 << FRAC_BITS))
                e = 64'd1 << FRAC_BITS;
            tbl[k] = SCALE_W'(e);
        end
        return tbl;
    endfunction

    localparam sin2_table_t SIN2_TABLE = build_sin2_table();

    // Round half up by 2^-F, saturate to 32 bits unsigned
    function automatic logic [31:0] round_sat_u32(input logic [63:0] x);
        logic [64:0] s;
        s = ({1'b0, x} + 65'(ROUND_HALF)) >> FRAC_BITS;
        return (|s[64:32]) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/sld_lane.sv @@
`default_nettype none

// One velocity component: |rho*v|, scale by gain, sign and saturate.
module sld_lane
    import sld_pkg::*;
(
    input  wire logic                    clk,
    input  wire sld_adv_t                adv,
    input  wire logic signed [DATA_W-1:0] density,
    input  wire logic signed [DATA_W-1:0] vel,
    input  wire logic [31:0]             gain,
    input  wire logic                    in_layer,
    output logic signed [DATA_W-1:0]     damp
);

    logic [32:0] rho_ext;
    logic [32:0] vel_ext;
    logic [32:0] rho_mag;
    logic [32:0] vel_mag;

    logic [31:0] rho_abs_reg;
    logic [31:0] vel_abs_reg;
    logic [63:0] mag_prod_reg;
    logic [31:0] m_reg [2:7];
    logic        neg_reg [0:8];
    logic [63:0] mg_prod_reg;
    logic signed [DATA_W-1:0] damp_reg;
    logic signed [DATA_W-1:0] damp_next;

    logic [64:0] r_sum;
    logic [64:0] r_val;

    assign rho_ext = {density[31], density};
    assign vel_ext = {vel[31], vel};
    assign rho_mag = density[31] ? (~rho_ext + 33'd1) : rho_ext;
    assign vel_mag = vel[31] ? (~vel_ext + 33'd1) : vel_ext;

    assign r_sum = {1'b0, mg_prod_reg} + 65'(ROUND_HALF);
    assign r_val = r_sum >> FRAC_BITS;

    always_comb
    begin
        if (!in_layer)
            damp_next = '0;
        else if (neg_reg[8])
        begin
            if (r_val > 65'h8000_0000)
                damp_next = 32'sh8000_0000;
            else
                damp_next = 32'(65'd0 - r_val);
        end
        else if (r_val > 65'h7FFF_FFFF)
            damp_next = 32'sh7FFF_FFFF;
        else
            damp_next = r_val[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            rho_abs_reg <= rho_mag[31:0];
            vel_abs_reg <= vel_mag[31:0];
            neg_reg[0]  <= density[31] ^ vel[31];
        end
        if (adv[1])
            mag_prod_reg <= 64'(rho_abs_reg) * 64'(vel_abs_reg);
        if (adv[2])
            m_reg[2] <= round_sat_u32(mag_prod_reg);
        for (int k = 3; k <= 7; k++)
        begin
            if (adv[k])
                m_reg[k] <= m_reg[k-1];
        end
        for (int k = 1; k <= 8; k++)
        begin
            if (adv[k])
                neg_reg[k] <= neg_reg[k-1];
        end
        if (adv[8])
            mg_prod_reg <= 64'(m_reg[7]) * 64'(gain);
        if (adv[9])
            damp_reg <= damp_next;
    end

    assign damp = damp_reg;

endmodule

`default_nettype wire

@@ sv/sponge_layer_damping_top.sv @@
// Sponge layer damping, one grid cell per transfer.
// Input channel (in_valid/in_ready) carries face_position, density and
// vel_x/y/z, all signed Q16.16. Output channel (out_valid/out_ready)
// carries damp_x/y/z (saturated Q16.16 decrements) and in_layer.
// Configuration: cfg_write_en/cfg_index/cfg_data writes one register per
// cycle, no wait; write only while the pipeline holds no cell.
// Pipeline: 10 register stages, output register included, lie between an
// accepted cell and its result on the output.
// Throughput: one cell per cycle unless stalled; the multipliers are fully
// pipelined (eta, scale*dt, *1/tau, rho*v and m*g each get their own stage).
// Stall: each stage holds while the one after it is full and stalled;
// bubbles close up, so in_ready drops only when all 10 stages are full
// and out_ready is low. Nothing is dropped or repeated.
// Reset: stage valid bits clear; registers return to boundary 0, upper
// side, width, 1/width, 1/tau and dt all 1.0.
`default_nettype none

module sponge_layer_damping_top
    import sld_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [DATA_W-1:0]        cfg_data,

    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [DATA_W-1:0] face_position,
    input  wire logic signed [DATA_W-1:0] density,
    input  wire logic signed [DATA_W-1:0] vel_x,
    input  wire logic signed [DATA_W-1:0] vel_y,
    input  wire logic signed [DATA_W-1:0] vel_z,

    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      damp_x,
    output logic signed [DATA_W-1:0]      damp_y,
    output logic signed [DATA_W-1:0]      damp_z,
    output logic                          in_layer
);

    // ---------------- configuration registers ----------------
    logic signed [31:0] boundary_reg;
    logic               from_upper_reg;
    logic [30:0]        width_reg;
    logic [30:0]        inv_width_reg;
    logic [30:0]        inv_tau_reg;
    logic [30:0]        time_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boundary_reg   <= '0;
            from_upper_reg <= 1'b1;
            width_reg      <= ONE_Q31;
            inv_width_reg  <= ONE_Q31;
            inv_tau_reg    <= ONE_Q31;
            time_step_reg  <= ONE_Q31;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_BOUNDARY_POSITION:  boundary_reg   <= cfg_data;
                REG_MEASURE_FROM_UPPER: from_upper_reg <= cfg_data[0];
                REG_LAYER_WIDTH:        width_reg      <= cfg_data[30:0];
                REG_INVERSE_WIDTH:      inv_width_reg  <= cfg_data[30:0];
                REG_INVERSE_TAU:        inv_tau_reg    <= cfg_data[30:0];
                REG_TIME_STEP:          time_step_reg  <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // vld_reg[k] marks a cell in stage k; adv[k] lets stage k load.
    logic [NUM_STAGES-1:0] vld_reg;
    sld_adv_t              adv;

    always_comb
    begin
        adv[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
            adv[k] = !vld_reg[k] || adv[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (adv[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NUM_STAGES-1];

    // ---------------- eta / gain path ----------------
    logic signed [33:0] distance;
    logic signed [33:0] num;

    logic [33:0]            num_reg;
    logic                   layer_reg [0:NUM_STAGES-1];
    logic [ETA_PROD_W-1:0]  eta_prod_reg;
    logic [PH_W-1:0]        ph_reg;
    logic [SCALE_W-1:0]     scale_reg;
    logic [ST_PROD_W-1:0]   st_prod_reg;
    logic [30:0]            a_reg;
    logic [61:0]            at_prod_reg;
    logic [31:0]            gain_reg;

    logic [63:0]            eta_full;
    logic [ETA_PROD_W:0]    eta_sum;
    logic [PH_W-1:0]        eta_lo;
    logic [PH_W-1:0]        ph_next;
    logic [IDXP_W-1:0]      idx_full;
    logic [IDX_W-1:0]       idx;
    logic [ST_PROD_W:0]     a_sum;

    // Stage 0: distance from the boundary, numerator of eta
    assign distance = from_upper_reg
                      ? ({{2{boundary_reg[31]}}, boundary_reg}
                         - {{2{face_position[31]}}, face_position})
                      : ({{2{face_position[31]}}, face_position}
                         - {{2{boundary_reg[31]}}, boundary_reg});
    assign num  = $signed({3'b000, width_reg}) - distance;

    // Stage 2: only eta mod 2.0 matters, so the low product bits suffice
    assign eta_full = 64'(num_reg[32:0]) * 64'(inv_width_reg);
    assign eta_sum  = {1'b0, eta_prod_reg} + (ETA_PROD_W+1)'(ROUND_HALF);
    assign eta_lo   = eta_sum[2*FRAC_BITS:FRAC_BITS];
    // fold phase above 1.0 back: 2.0 - phase, modulo 2.0
    assign ph_next  = (eta_lo > PH_W'(64'd1 << FRAC_BITS)) ? (PH_W'(0) - eta_lo) : eta_lo;

    // Stage 3: table index = round(phase * DEPTH)
    assign idx_full = (IDXP_W'(ph_reg) * IDXP_W'(SIN2_DEPTH) + IDXP_W'(ROUND_HALF))
                      >> FRAC_BITS;
    assign idx      = (idx_full > IDXP_W'(SIN2_DEPTH)) ? IDX_W'(SIN2_DEPTH)
                                                       : idx_full[IDX_W-1:0];

    // Stage 5: scale*dt rounded never exceeds dt, fits 31 bits
    assign a_sum = {1'b0, st_prod_reg} + (ST_PROD_W+1)'(ROUND_HALF);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            num_reg      <= num;
            layer_reg[0] <= !num[33];
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (adv[k])
                layer_reg[k] <= layer_reg[k-1];
        end
        if (adv[1])
            eta_prod_reg <= eta_full[ETA_PROD_W-1:0];
        if (adv[2])
            ph_reg <= ph_next;
        if (adv[3])
            scale_reg <= SIN2_TABLE[idx];
        if (adv[4])
            st_prod_reg <= ST_PROD_W'(scale_reg) * ST_PROD_W'(time_step_reg);
        if (adv[5])
            a_reg <= a_sum[FRAC_BITS+30:FRAC_BITS];
        if (adv[6])
            at_prod_reg <= 62'(a_reg) * 62'(inv_tau_reg);
        if (adv[7])
            gain_reg <= round_sat_u32(64'(at_prod_reg));
    end

    // ---------------- velocity lanes ----------------
    sld_lane u_lane_x
    (
        .clk      (clk),
        .adv      (adv),
        .density  (density),
        .vel      (vel_x),
        .gain     (gain_reg),
        .in_layer (layer_reg[8]),
        .damp     (damp_x)
    );

    sld_lane u_lane_y
    (
        .clk      (clk),
        .adv      (adv),
        .density  (density),
        .vel      (vel_y),
        .gain     (gain_reg),
        .in_layer (layer_reg[8]),
        .damp     (damp_y)
    );

    sld_lane u_lane_z
    (
        .clk      (clk),
        .adv      (adv),
        .density  (density),
        .vel      (vel_z),
        .gain     (gain_reg),
        .in_layer (layer_reg[8]),
        .damp     (damp_z)
    );

    assign in_layer = layer_reg[NUM_STAGES-1];

    // ---------------- assertions ----------------
    // cells outside the layer never carry a decrement
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_layer |-> damp_x == '0 && damp_y == '0 && damp_z == '0)
        else $error("nonzero damping outside layer");

    // backpressure only when every stage is full and the sink stalls
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&vld_reg) && !out_ready)
        else $error("input stalled with room in pipeline");

    // a cell moving into the output stage arrives there
    a_last_move: assert property (@(posedge clk) disable iff (!rst_n)
        adv[NUM_STAGES-1] && vld_reg[NUM_STAGES-2] |=> out_valid)
        else $error("cell lost before output stage");

    // an accepted cell occupies the first stage next cycle
    a_first_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted cell not captured");

endmodule

`default_nettype wire

@@ test/sponge_damping_checker.sv @@
module sponge_damping_checker
    import sld_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write_en,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic signed [DATA_W-1:0] face_position,
    input  logic signed [DATA_W-1:0] density,
    input  logic signed [DATA_W-1:0] vel_x,
    input  logic signed [DATA_W-1:0] vel_y,
    input  logic signed [DATA_W-1:0] vel_z,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [DATA_W-1:0] damp_x,
    input  logic signed [DATA_W-1:0] damp_y,
    input  logic signed [DATA_W-1:0] damp_z,
    input  logic                     in_layer,
    output int                       mismatches,
    output int                       outstanding,
    output int                       results_checked,
    output int                       layer_hits,
    output int                       stall_cycles
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 60;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic               hit;
    } damping_t;

    // Shadow copy of the register file
    logic signed [31:0] bound_q      = '0;
    logic               from_upper_q = 1'b1;
    logic [30:0]        width_q      = ONE_Q31;
    logic [30:0]        inv_width_q  = ONE_Q31;
    logic [30:0]        inv_tau_q    = ONE_Q31;
    logic [30:0]        step_q       = ONE_Q31;

    logic [FRAC_BITS:0] sin_sq_lut [0:SIN2_DEPTH];
    damping_t           expected_damps [$];

    // sin^2 over a quarter wave: Taylor series of sin in Q30, then squared
    initial
    begin
        u64_t   ang;
        u64_t   ang_sq;
        u64_t   term;
        u64_t   sq;
        u64_t   q;
        longint acc;
        for (int k = 0; k <= SIN2_DEPTH; k++)
        begin
            ang    = (HALF_PI_Q30 * u64_t'(k) + u64_t'(SIN2_DEPTH / 2)) / u64_t'(SIN2_DEPTH);
            ang_sq = (ang * ang) >> 30;
            term   = ang;
            acc    = longint'(ang);
            for (int n = 1; n < 20 && term != 0; n++)
            begin
                term = ((term * ang_sq) >> 30) / u64_t'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            if (acc > longint'(64'd1 << 30))
                acc = longint'(64'd1 << 30);
            sq = u64_t'(acc) * u64_t'(acc);
            q  = (sq + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
            if (q > (64'd1 << FRAC_BITS))
                q = 64'd1 << FRAC_BITS;
            sin_sq_lut[k] = q[FRAC_BITS:0];
        end
    end

    function automatic u64_t round_q(input u64_t x);
        return (x + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    endfunction

    // |rho*v| and the gain are rounded and clipped; sign applied last
    function automatic logic signed [31:0] scaled_decrement(
        input logic signed [31:0] rho,
        input logic signed [31:0] v,
        input u64_t               gain
    );
        logic neg;
        u64_t ar;
        u64_t av;
        u64_t m;
        u64_t r;
        neg = rho[31] ^ v[31];
        ar  = u64_t'(rho[31] ? -longint'(rho) : longint'(rho));
        av  = u64_t'(v[31] ? -longint'(v) : longint'(v));
        m   = round_q(ar * av);
        if (m > 64'hFFFF_FFFF)
            m = 64'hFFFF_FFFF;
        r = round_q(m * gain);
        if (neg)
        begin
            if (r > 64'h8000_0000)
                r = 64'h8000_0000;
            r = 64'd0 - r;
            return r[31:0];
        end
        if (r > 64'h7FFF_FFFF)
            r = 64'h7FFF_FFFF;
        return r[31:0];
    endfunction

    function automatic damping_t predict_damping(
        input logic signed [31:0] face,
        input logic signed [31:0] rho,
        input logic signed [31:0] vx,
        input logic signed [31:0] vy,
        input logic signed [31:0] vz
    );
        longint   reach;
        longint   slack;
        u64_t     eta;
        u64_t     phase;
        u64_t     slot;
        u64_t     scale;
        u64_t     gain;
        damping_t res;
        res   = '0;
        reach = from_upper_q ? longint'(bound_q) - longint'(face)
                             : longint'(face) - longint'(bound_q);
        slack = longint'(width_q) - reach;
        if (slack < 0)
            return res;
        eta   = round_q(u64_t'(slack) * u64_t'(inv_width_q));
        // sin^2 has period 2 in eta; fold the upper half back
        phase = eta & ((64'd2 << FRAC_BITS) - 1);
        if (phase > (64'd1 << FRAC_BITS))
            phase = (64'd2 << FRAC_BITS) - phase;
        slot = round_q(phase * u64_t'(SIN2_DEPTH));
        if (slot > u64_t'(SIN2_DEPTH))
            slot = u64_t'(SIN2_DEPTH);
        scale = u64_t'(sin_sq_lut[slot]);
        gain  = round_q(round_q(scale * u64_t'(step_q)) * u64_t'(inv_tau_q));
        if (gain > 64'hFFFF_FFFF)
            gain = 64'hFFFF_FFFF;
        res.dx  = scaled_decrement(rho, vx, gain);
        res.dy  = scaled_decrement(rho, vy, gain);
        res.dz  = scaled_decrement(rho, vz, gain);
        res.hit = 1'b1;
        return res;
    endfunction

    task automatic note_mismatch(input string field, input longint want, input longint got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        else if (mismatches == REPORT_LIMIT + 1)
            $display("%0t: more mismatches follow, counted only", $time);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        damping_t want;
        if (!rst_n)
        begin
            bound_q      = '0;
            from_upper_q = 1'b1;
            width_q      = ONE_Q31;
            inv_width_q  = ONE_Q31;
            inv_tau_q    = ONE_Q31;
            step_q       = ONE_Q31;
            expected_damps.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_BOUNDARY_POSITION:  bound_q      = cfg_data;
                    REG_MEASURE_FROM_UPPER: from_upper_q = cfg_data[0];
                    REG_LAYER_WIDTH:        width_q      = cfg_data[30:0];
                    REG_INVERSE_WIDTH:      inv_width_q  = cfg_data[30:0];
                    REG_INVERSE_TAU:        inv_tau_q    = cfg_data[30:0];
                    REG_TIME_STEP:          step_q       = cfg_data[30:0];
                    default:                ;
                endcase
            end

            if (in_valid && !in_ready)
                stall_cycles++;

            if (out_valid && out_ready)
            begin
                results_checked++;
                if (in_layer)
                    layer_hits++;
                if (expected_damps.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with no cell pending, expected none, actual %0d %0d %0d %0b",
                             $time, damp_x, damp_y, damp_z, in_layer);
                end
                else
                begin
                    want = expected_damps.pop_front();
                    if (damp_x !== want.dx)
                        note_mismatch("damp_x", want.dx, damp_x);
                    if (damp_y !== want.dy)
                        note_mismatch("damp_y", want.dy, damp_y);
                    if (damp_z !== want.dz)
                        note_mismatch("damp_z", want.dz, damp_z);
                    if (in_layer !== want.hit)
                        note_mismatch("in_layer", want.hit, in_layer);
                end
            end

            if (in_valid && in_ready)
                expected_damps.push_back(
                    predict_damping(face_position, density, vel_x, vel_y, vel_z));

            outstanding <= expected_damps.size();
        end
    end

endmodule

@@ test/sponge_layer_damping_top_tb.sv @@
module sponge_layer_damping_top_tb;
    import sld_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Q16.16 constants
    localparam logic signed [31:0] Q_ONE     = 32'sh0001_0000;
    localparam logic signed [31:0] Q_HALF    = 32'sh0000_8000;
    localparam logic signed [31:0] Q_QUARTER = 32'sh0000_4000;
    localparam logic signed [31:0] Q_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;
    localparam logic [30:0]        U_ONE     = 31'h0001_0000;
    localparam logic [30:0]        U_MAX     = 31'h7FFF_FFFF;

    // Indexes the block decodes to nothing
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

    localparam int CELLS_PER_SETTING = 76;
    localparam int HOLD_CYCLES       = 96;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_TOGGLE} sink_mode_e;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_write_en;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [DATA_W-1:0]        cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [DATA_W-1:0] face_position;
    logic signed [DATA_W-1:0] density;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] damp_x;
    logic signed [DATA_W-1:0] damp_y;
    logic signed [DATA_W-1:0] damp_z;
    logic                     in_layer;

    // Reported by the checker
    int mismatches;
    int outstanding;
    int results_checked;
    int layer_hits;
    int stall_cycles;

    // Current register image, used to aim face coordinates at the layer
    logic signed [31:0] cur_boundary = '0;
    logic               cur_upper    = 1'b1;
    logic [30:0]        cur_width    = U_ONE;

    int burst_left     = 0;
    int cells_sent     = 0;
    int settings_used  = 1;
    int hold_ticket    = 0;

    always
    begin
        #4ns clk = 1'b1;
        #4ns clk = 1'b0;
    end

    sponge_layer_damping_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .face_position (face_position),
        .density       (density),
        .vel_x         (vel_x),
        .vel_y         (vel_y),
        .vel_z         (vel_z),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .damp_x        (damp_x),
        .damp_y        (damp_y),
        .damp_z        (damp_z),
        .in_layer      (in_layer)
    );

    // Watches both channels and the register port, predicts and compares
    sponge_damping_checker u_checker (.*);

    // Sender: one cell per transfer. Cells go out in bursts of random
    // length; between bursts in_valid drops for a random gap. Once raised,
    // valid and payload hold until the transfer happens.
    task automatic offer_cell(input logic signed [31:0] face, rho, vx, vy, vz);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid      <= 1'b1;
        face_position <= face;
        density       <= rho;
        vel_x         <= vx;
        vel_y         <= vy;
        vel_z         <= vz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        cells_sent++;
    endtask

    // One register per cycle; the caller drops the write enable
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
    endtask

    task automatic load_settings(
        input logic signed [31:0] bnd,
        input logic               upper,
        input logic [30:0]        width,
        input logic [30:0]        inv_width,
        input logic [30:0]        inv_tau,
        input logic [30:0]        dt
    );
        write_reg(REG_BOUNDARY_POSITION, bnd);
        write_reg(REG_MEASURE_FROM_UPPER, {31'd0, upper});
        write_reg(REG_LAYER_WIDTH, {1'b0, width});
        write_reg(REG_INVERSE_WIDTH, {1'b0, inv_width});
        write_reg(REG_INVERSE_TAU, {1'b0, inv_tau});
        write_reg(REG_TIME_STEP, {1'b0, dt});
        cfg_write_en <= 1'b0;
        cur_boundary = bnd;
        cur_upper    = upper;
        cur_width    = width;
        settings_used++;
    endtask

    // Stop offering, then wait for the pipeline to empty. The checker's
    // count is registered, so the first sample already includes the last
    // transfer. Every cell yields a result, so an empty queue means idle;
    // a final wait past the stage depth follows anyway.
    task automatic settle();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (NUM_STAGES + 2) @(posedge clk);
    endtask

    // Density and velocity: mostly modest values, some rails, some raw bits
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return $urandom;
            default: return int'($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
        endcase
    endfunction

    // Face coordinate aimed at the layer of the current setting: inside,
    // exactly on its edges, just outside, beyond the boundary, or anywhere
    function automatic logic signed [31:0] pick_face();
        longint offset;
        longint spot;
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       offset = longint'(cur_width) + longint'($urandom_range(1, 4096));
            2:       offset = -longint'($urandom_range(0, cur_width));
            3:       offset = $urandom_range(0, 1) ? longint'(cur_width) : 0;
            default: offset = longint'($urandom_range(0, cur_width));
        endcase
        spot = cur_upper ? longint'(cur_boundary) - offset : longint'(cur_boundary) + offset;
        return spot[31:0];
    endfunction

    function automatic logic [30:0] pick_width();
        case ($urandom_range(0, 2))
            0:       return 31'($urandom_range(16, 32'h1_0000));
            1:       return 31'($urandom_range(32'h1_0000, 32'h100_0000));
            default: return 31'($urandom_range(1, 32'h7FFF_FFFF));
        endcase
    endfunction

    task automatic random_cells(input int count);
        for (int i = 0; i < count; i++)
            offer_cell(pick_face(), pick_value(), pick_value(), pick_value(), pick_value());
    endtask

    // Receiver: out_ready follows a pattern, picked at random and renewed
    // when its random run ends (always open, coin flip, rarely open, toggling). When the
    // stimulus asks for it, it also holds off for a long stretch so the
    // pipeline fills and in_ready drops.
    initial
    begin
        sink_mode_e mode;
        int         mode_left;
        int         hold_served;
        mode        = SINK_OPEN;
        mode_left   = 0;
        hold_served = 0;
        out_ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_ticket != hold_served)
            begin
                hold_served = hold_ticket;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = sink_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 80);
            end
            mode_left--;
            case (mode)
                SINK_OPEN:   out_ready <= 1'b1;
                SINK_COIN:   out_ready <= 1'($urandom_range(0, 1));
                SINK_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                SINK_TOGGLE: out_ready <= ~out_ready;
                default:     out_ready <= 1'b1;
            endcase
            @(posedge clk);
        end
    end

    // Stimulus
    initial
    begin
        logic [30:0]     width_pick;
        longint unsigned inv_pick;

        rst_n         <= 1'b0;
        cfg_write_en  <= 1'b0;
        cfg_index     <= REG_BOUNDARY_POSITION;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        face_position <= '0;
        density       <= '0;
        vel_x         <= '0;
        vel_y         <= '0;
        vel_z         <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cells on the reset registers: boundary 0 measured from
        // the upper side, width and all reciprocals 1.0, so eta = 1 + face.
        offer_cell('0, Q_ONE, Q_ONE, -Q_ONE, '0);                // eta 1, full damping
        offer_cell(-Q_ONE, Q_ONE, Q_ONE, -Q_ONE, Q_MAX);         // eta 0, inner edge
        offer_cell(-Q_ONE - 1, Q_ONE, Q_ONE, Q_ONE, Q_ONE);      // just outside
        offer_cell(-Q_HALF, 32'sh0002_0000, 32'sh0003_0000, -Q_HALF, 32'sd1);
        offer_cell(Q_HALF, 32'sh0002_0000, 32'sh0003_0000, -Q_HALF, 32'sd1); // eta 1.5 folds
        offer_cell(Q_ONE, Q_ONE, Q_ONE, -Q_ONE, Q_HALF);         // eta 2, phase back to 0
        offer_cell(Q_MAX, Q_MAX, Q_MAX, Q_MIN, '0);              // far past the boundary
        offer_cell(Q_MIN, Q_ONE, Q_ONE, Q_ONE, Q_ONE);           // far outside the layer
        offer_cell('0, Q_MIN, Q_MIN, Q_MAX, 32'sd1);             // product saturation both ways
        offer_cell('0, '0, Q_MAX, Q_MIN, 32'sh1234_5678);        // zero density
        offer_cell(-Q_QUARTER, Q_MAX, Q_MAX, Q_MAX, Q_MIN);
        offer_cell('0, -Q_ONE, Q_MIN, 32'sh7FFF_0000, -32'sd1);
        offer_cell('0, 32'sd1, 32'sd1, -32'sd1, Q_HALF);         // rounding of tiny products
        offer_cell('0, Q_HALF, 32'sd1, -32'sd1, 32'sd3);         // half-way ties, both signs
        settle();

        // Lower side, moderate layer; the receiver also holds off here
        load_settings(32'sh000A_0000, 1'b0, 31'h0004_0000, 31'h0000_4000,
                      31'h0002_0000, 31'h0000_199A);
        hold_ticket++;
        random_cells(CELLS_PER_SETTING);
        settle();

        // Width, 1/tau and dt at their top end: the gain and products saturate
        load_settings(Q_MIN, 1'b1, U_MAX, 31'd1, U_MAX, U_MAX);
        random_cells(CELLS_PER_SETTING);
        settle();

        // Zero thickness: only cells at or past the boundary count
        load_settings(32'sh0012_3456, 1'b0, 31'd0, U_MAX, U_ONE, U_ONE);
        random_cells(CELLS_PER_SETTING);
        settle();

        // Zero reciprocals and step; the unused indexes get a write too
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);
        load_settings(32'shFFF0_0000, 1'b1, 31'h0008_0000, 31'd0, 31'd0, 31'd0);
        random_cells(CELLS_PER_SETTING);
        settle();

        // Thin layer at the top rail with a huge 1/width: eta wraps often
        load_settings(Q_MAX, 1'b0, 31'h0000_0100, U_MAX, U_ONE, U_ONE);
        hold_ticket++;
        random_cells(CELLS_PER_SETTING);
        settle();

        // Random settings; 1/width mostly matches the width
        for (int p = 0; p < 4; p++)
        begin
            width_pick = pick_width();
            inv_pick   = 64'h1_0000_0000 / width_pick;
            if (inv_pick > 64'h7FFF_FFFF)
                inv_pick = 64'h7FFF_FFFF;
            if ($urandom_range(0, 3) == 0)
                inv_pick = $urandom_range(1, 32'h7FFF_FFFF);
            load_settings($urandom, 1'($urandom_range(0, 1)), width_pick, inv_pick[30:0],
                          31'($urandom_range(0, 32'h8_0000)),
                          31'($urandom_range(0, 32'h2_0000)));
            random_cells(CELLS_PER_SETTING);
            settle();
        end

        repeat (20) @(posedge clk);
        $display("Sent %0d cells under %0d register settings; %0d results compared, %0d in the layer.",
                 cells_sent, settings_used, results_checked, layer_hits);
        $display("Input side was held off by backpressure for %0d cycles.", stall_cycles);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #2ms;
        $display("Timeout with %0d results still pending.", outstanding);
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
sv/sld_pkg.sv
sv/sld_lane.sv
sv/sponge_layer_damping_top.sv
test/sponge_damping_checker.sv
test/sponge_layer_damping_top_tb.sv
